### src/lhbp_pkg.sv
// ----------------------------------------------------------------------------
// lhbp_pkg
// Shared types, constants and the counter step function of the local
// history branch predictor.
// ----------------------------------------------------------------------------
package lhbp_pkg;

   localparam int PC_WIDTH = 32;

   typedef logic [PC_WIDTH-1:0] pc_type;
   typedef logic [1:0]          ctr_type;

   localparam ctr_type CTR_MIN = 2'd0;
   localparam ctr_type CTR_MAX = 2'd3;

   // Move a two-bit saturating counter one step toward the outcome.
   function automatic ctr_type step_counter(input ctr_type c, input logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + 2'd1;
      end else begin
         if (c != CTR_MIN) r = c - 2'd1;
      end
      return r;
   endfunction

endpackage

### src/lhbp_if.sv
// ----------------------------------------------------------------------------
// lhbp_req_if / lhbp_rsp_if
// Valid/ready channels that carry the branch request word and the
// prediction word.
// ----------------------------------------------------------------------------
interface lhbp_req_if import lhbp_pkg::*; ();
   logic   valid;
   logic   ready;
   logic   kind;
   pc_type pc;
   logic   taken;

   modport source (output valid, output kind, output pc, output taken, input ready);
   modport sink   (input valid, input kind, input pc, input taken, output ready);
endinterface

interface lhbp_rsp_if;
   logic valid;
   logic ready;
   logic predict_taken;

   modport source (output valid, output predict_taken, input ready);
   modport sink   (input valid, input predict_taken, output ready);
endinterface

### src/local_history_branch_predictor.sv
// ----------------------------------------------------------------------------
// local_history_branch_predictor
// Two-level local branch predictor built around two synchronous memories.
// ----------------------------------------------------------------------------
// Each request word carries a branch address; pc[INDEX_BITS+1:2] selects an
// entry of the history memory, and the entry number joined with its
// HISTORY_BITS-bit history selects a two-bit counter in the counter memory.
// The response word returns the counter's upper bit as read before the request
// is applied; an update request (kind = 1) then steps the counter toward the
// outcome and shifts the outcome into the history at bit 0. A request runs
// through a read of the history memory, a dependent read of the counter
// memory, then the write-back, which waits for a free response register; no
// new word is taken until it is done. The response register lets a request be
// accepted while the previous prediction still waits. After reset the block
// zeroes both memories in a clearing pass over all 2^(INDEX_BITS+HISTORY_BITS)
// counter slots (4096 at the defaults); no request is accepted until it ends.
// ----------------------------------------------------------------------------
module local_history_branch_predictor
   import lhbp_pkg::*;
#(
   parameter int INDEX_BITS   = 8,
   parameter int HISTORY_BITS = 4
) (
   input  logic         clock,
   input  logic         reset,
   lhbp_req_if.sink     req_chan,
   lhbp_rsp_if.source   rsp_chan
);

   localparam int CTR_BITS   = INDEX_BITS + HISTORY_BITS;
   localparam int HIST_DEPTH = 1 << INDEX_BITS;
   localparam int CTR_DEPTH  = 1 << CTR_BITS;

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;  // zero both memories
   localparam logic [2:0] S_IDLE  = 3'd1;  // take a request, read history
   localparam logic [2:0] S_HRD   = 3'd2;  // history ready, read counter
   localparam logic [2:0] S_CRD   = 3'd3;  // counter ready, respond, write back

   // memories
   logic [HISTORY_BITS-1:0] hist_mem [HIST_DEPTH];
   ctr_type                 ctr_mem  [CTR_DEPTH];

   // control state
   logic [2:0]          state_ff, state_in;
   logic [CTR_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                    kind_ff;
   logic                    taken_ff;
   logic [INDEX_BITS-1:0]   entry_ff;
   logic [CTR_BITS-1:0]     ctr_idx_ff;
   logic [HISTORY_BITS-1:0] hist_rd_ff;
   ctr_type                 ctr_rd_ff;
   logic                    pred_ff, pred_in;

   // memory ports
   logic                    hist_re, hist_we, ctr_re, ctr_we;
   logic [INDEX_BITS-1:0]   hist_raddr, hist_waddr;
   logic [HISTORY_BITS-1:0] hist_wdata;
   logic [CTR_BITS-1:0]     ctr_raddr, ctr_waddr;
   ctr_type                 ctr_wdata;
   logic [HISTORY_BITS:0]   hist_shift;

   logic req_fire, out_free, finish;

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign req_fire               = req_chan.valid && req_chan.ready;
   assign out_free               = !rsp_valid_ff || rsp_chan.ready;
   assign finish                 = (state_ff == S_CRD) && out_free;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.predict_taken = pred_ff;

   // Shift the outcome into the history at bit 0; drop the oldest bit.
   assign hist_shift = {hist_rd_ff, taken_ff};

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      pred_in      = pred_ff;

      hist_re    = 1'b0;
      hist_raddr = req_chan.pc[INDEX_BITS+1:2];
      hist_we    = 1'b0;
      hist_waddr = entry_ff;
      hist_wdata = hist_shift[HISTORY_BITS-1:0];
      ctr_re     = 1'b0;
      ctr_raddr  = {entry_ff, hist_rd_ff};
      ctr_we     = 1'b0;
      ctr_waddr  = ctr_idx_ff;
      ctr_wdata  = step_counter(ctr_rd_ff, taken_ff);

      // a waiting response leaves once taken
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_cnt_ff[INDEX_BITS-1:0];
            hist_wdata = '0;
            ctr_we     = 1'b1;
            ctr_waddr  = clr_cnt_ff;
            ctr_wdata  = CTR_MIN;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CTR_BITS'(CTR_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               hist_re  = 1'b1;
               state_in = S_HRD;
            end
         end
         S_HRD: begin
            ctr_re   = 1'b1;
            state_in = S_CRD;
         end
         S_CRD: begin
            // hold the counter word until the response register is free
            if (out_free) begin
               pred_in      = ctr_rd_ff[1];
               rsp_valid_in = 1'b1;
               hist_we      = kind_ff;
               ctr_we       = kind_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the request word and the response bit
   always_ff @(posedge clock) begin
      pred_ff <= pred_in;
      if (req_fire) begin
         kind_ff  <= req_chan.kind;
         taken_ff <= req_chan.taken;
         entry_ff <= req_chan.pc[INDEX_BITS+1:2];
      end
      if (ctr_re) ctr_idx_ff <= ctr_raddr;
   end

   // history memory, registered read
   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      if (hist_re) hist_rd_ff <= hist_mem[hist_raddr];
   end

   // counter memory, registered read
   always_ff @(posedge clock) begin
      if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
      if (ctr_re) ctr_rd_ff <= ctr_mem[ctr_raddr];
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_no_req_in_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_chan.ready)
      else $error("request taken during clearing pass");

   a_rsp_from_counter : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> ($past(state_ff) == S_CRD))
      else $error("response raised outside the counter stage");

   a_write_phase : assert property (@(posedge clock) disable iff (reset)
      ctr_we |-> ((state_ff == S_CLEAR) || finish))
      else $error("counter memory written outside clear or write-back");

   a_hist_ctr_paired : assert property (@(posedge clock) disable iff (reset)
      hist_we |-> ctr_we)
      else $error("history written without its counter");

   a_accept_to_read : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_HRD) ##1 (state_ff == S_CRD))
      else $error("request did not walk through both memory reads");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the local history branch predictor. Request words
// come from a short table of corner cases and then from a mix of hot,
// aliased and scattered branch addresses. A local copy of the history and
// counter tables predicts each unpinned response word, and the responses are
// checked in order while both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import lhbp_pkg::*;

   // Geometry of the block as instantiated (default parameters).
   localparam int ENTRY_W = 8;
   localparam int HIST_W  = 4;

   // Request kinds and outcomes.
   localparam logic KIND_PREDICT = 1'b0;
   localparam logic KIND_UPDATE  = 1'b1;
   localparam logic NOT_TAKEN    = 1'b0;
   localparam logic TAKEN        = 1'b1;

   // Run control.
   localparam int RANDOM_WORDS    = 1950;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 12;
   // Covers the clearing pass and the long response hold several times
   // over.
   localparam int IDLE_LIMIT      = 20000;

   // One row of the corner-case table. A pinned row carries its response by
   // hand; other rows take the response from the local tables.
   typedef struct packed {
      logic   kind;
      pc_type pc;
      logic   taken;
      logic   pinned;
      logic   pinned_value;
   } branch_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam branch_row_type DIRECTED_WORDS [DIRECTED_ROWS] = '{
      // Fresh tables predict not taken everywhere, lowest and highest address.
      '{KIND_PREDICT, 32'h0000_0000, NOT_TAKEN, 1'b1, 1'b0},
      '{KIND_PREDICT, 32'hFFFF_FFFF, TAKEN,     1'b1, 1'b0},
      // Not-taken saturation: counter stays at zero, history stays zero.
      '{KIND_UPDATE,  32'hFFFF_FFFF, NOT_TAKEN, 1'b1, 1'b0},
      '{KIND_UPDATE,  32'hFFFF_FFFC, NOT_TAKEN, 1'b1, 1'b0},
      // Train entry 8 taken: history fills with ones, then the all-ones
      // counter climbs to 3 and sticks there (taken saturation).
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b0},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b0},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b0},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b0},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b0},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b0},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b1},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b1},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b1, 1'b1},
      // Aliases of entry 8: other upper bits, and stray low bits.
      '{KIND_PREDICT, 32'h0000_0420, NOT_TAKEN, 1'b1, 1'b1},
      '{KIND_PREDICT, 32'hFFFF_FC23, TAKEN,     1'b1, 1'b1},
      // Step down from 3; history moves off all ones.
      '{KIND_UPDATE,  32'h0000_0020, NOT_TAKEN, 1'b1, 1'b1},
      '{KIND_PREDICT, 32'h0000_0020, TAKEN,     1'b0, 1'b0},
      '{KIND_UPDATE,  32'h7FFF_FFF8, TAKEN,     1'b0, 1'b0},
      '{KIND_UPDATE,  32'h8000_0004, NOT_TAKEN, 1'b0, 1'b0},
      '{KIND_UPDATE,  32'h0000_0020, TAKEN,     1'b0, 1'b0},
      '{KIND_UPDATE,  32'hAAAA_AAAA, TAKEN,     1'b0, 1'b0},
      '{KIND_UPDATE,  32'h5555_5555, NOT_TAKEN, 1'b0, 1'b0},
      '{KIND_PREDICT, 32'h5555_5555, TAKEN,     1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   lhbp_req_if req_if ();
   lhbp_rsp_if rsp_if ();

   local_history_branch_predictor u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Local copy of the predictor state.
   logic [HIST_W-1:0] hist_mem [0:(1 << ENTRY_W)-1];
   logic [1:0]        ctr_mem  [0:(1 << (ENTRY_W + HIST_W))-1];

   logic expected_predictions [$];
   int   mismatches   = 0;
   logic pinned_word  = 1'b0;
   logic pinned_value = 1'b0;
   bit   hold_request = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Look up the prediction for one request word, then train on it if it
   // is an update.
   function automatic logic lookup_and_train(input logic kind, input pc_type pc,
                                             input logic taken);
      logic [ENTRY_W-1:0]        entry;
      logic [HIST_W-1:0]         hist;
      logic [ENTRY_W+HIST_W-1:0] slot;
      ctr_type                   ctr;
      entry = pc[ENTRY_W+1:2];
      hist  = hist_mem[entry];
      slot  = {entry, hist};
      ctr   = ctr_mem[slot];
      if (kind == KIND_UPDATE) begin
         if (taken == TAKEN) begin
            if (ctr != CTR_MAX) ctr_mem[slot] = ctr + 2'd1;
         end else begin
            if (ctr != CTR_MIN) ctr_mem[slot] = ctr - 2'd1;
         end
         hist_mem[entry] = {hist[HIST_W-2:0], taken};
      end
      return ctr[1];
   endfunction

   // Offer one request word at the falling edge and hold it until taken.
   task automatic send_word(input logic kind, input pc_type pc, input logic taken,
                            input logic pin, input logic pin_val);
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.pc    <= pc;
      req_if.taken <= taken;
      pinned_word  <= pin;
      pinned_value <= pin_val;
      do @(posedge clock); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
   endtask

   // Drop valid and wait until every outstanding prediction has come back.
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_predictions.size() != 0) @(posedge clock);
   endtask

   // Random branch traffic. Most words hit a small set of hot branches with
   // loop-like outcome patterns so the histories and counters get deep;
   // the rest are aliases of hot branches and scattered addresses.
   task automatic run_branch_mix(input int count);
      pc_type hot_pc [8];
      int     period [8];
      int     trip   [8];
      int     sent;
      int     burst;
      int     gap;
      int     slot;
      int     roll;
      logic   kind;
      logic   taken;
      pc_type pc;
      pc_type flip;
      for (int i = 0; i < 8; i++) begin
         hot_pc[i] = $urandom();
         period[i] = $urandom_range(2, 9);
         trip[i]   = 0;
      end
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 32);
         for (int b = 0; b < burst && sent < count; b++) begin
            roll = $urandom_range(0, 99);
            slot = $urandom_range(0, 7);
            kind = ($urandom_range(0, 99) < 80) ? KIND_UPDATE : KIND_PREDICT;
            if (roll < 60) begin
               // Loop branch: taken except at the end of each trip, with noise.
               pc    = hot_pc[slot];
               taken = (trip[slot] % period[slot] != period[slot] - 1);
               if ($urandom_range(0, 19) == 0) taken = ~taken;
               if (kind == KIND_UPDATE) trip[slot]++;
            end else if (roll < 75) begin
               // Same entry, different tag bits and byte offset.
               flip = $urandom();
               flip[ENTRY_W+1:2] = '0;
               pc    = hot_pc[slot] ^ flip;
               taken = 1'($urandom_range(0, 1));
            end else begin
               pc    = $urandom();
               taken = 1'($urandom_range(0, 1));
            end
            send_word(kind, pc, taken, 1'b0, 1'b0);
            sent++;
            // Stall the response side for a long stretch while words keep
            // coming, and later let the block empty out completely.
            if (sent == count / 3) hold_request = 1'b1;
            if (sent == 2 * count / 3) drain_results();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Response side: phases of full rate, random stalls and fixed patterns,
   // plus one long hold when asked.
   initial begin : rsp_stall_pattern
      int cyc;
      int hold_left;
      cyc = 0;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = RSP_HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            case ((cyc / 64) % 4)
               0: begin
                  rsp_if.ready <= 1'b1;
               end
               1: begin
                  rsp_if.ready <= ($urandom_range(0, 9) >= 4);
               end
               2: begin
                  rsp_if.ready <= (cyc % 5 != 0);
               end
               default: begin
                  rsp_if.ready <= (cyc % 7 < 3);
               end
            endcase
         end
      end
   end

   // Predict each accepted request word and queue the expected response.
   always @(posedge clock) begin : req_monitor
      logic guess;
      if (!reset && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
         guess = lookup_and_train(req_if.kind, req_if.pc, req_if.taken);
         expected_predictions = {expected_predictions,
                                 (pinned_word ? pinned_value : guess)};
      end
   end

   // Check each accepted response word against the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      logic want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_predictions.size() == 0) begin
            $display("%0t: unexpected prediction word, actual %0b",
                     $time, rsp_if.predict_taken);
            mismatches++;
         end else begin
            want = expected_predictions.pop_front();
            if (rsp_if.predict_taken !== want) begin
               $display("%0t: predict_taken mismatch, expected %0b, actual %0b",
                        $time, want, rsp_if.predict_taken);
               mismatches++;
            end
         end
      end
   end

   // Abort when neither channel moves for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      req_if.valid = 1'b0;
      req_if.kind  = KIND_PREDICT;
      req_if.pc    = '0;
      req_if.taken = NOT_TAKEN;
      foreach (hist_mem[i]) hist_mem[i] = '0;
      foreach (ctr_mem[i]) ctr_mem[i] = CTR_MIN;

      // Hold reset at the start, then release it; the block clears its tables
      // on its own before it takes the first word.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the corner-case table back to back.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_word(DIRECTED_WORDS[i].kind, DIRECTED_WORDS[i].pc, DIRECTED_WORDS[i].taken,
                   DIRECTED_WORDS[i].pinned, DIRECTED_WORDS[i].pinned_value);
      end
      drain_results();

      run_branch_mix(RANDOM_WORDS);
      drain_results();

      // Give a stray late word time to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_predictions.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
